### sv/lafd_pkg.sv
`timescale 1ns / 1ps

package lafd_pkg;

    localparam int FRAC_BITS = 2;

    // field widths
    localparam int BASE_W   = 8;
    localparam int CODE_W   = 3;
    localparam int COL_W    = 6;
    localparam int SCORE_W  = 16;
    localparam int GAP_W    = 18;   // signed working width for scores and gaps
    localparam int AWARD_W  = 10;
    localparam int CHARGE_W = 11;
    localparam int PEN_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_DATA_W = 48;

    localparam logic [SCORE_W-1:0] SCORE_CAP = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AWARD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTEND = 2'd3;

    // reset values, fixed point
    localparam logic [AWARD_W-1:0]         AWARD_RST  = AWARD_W'(5 << FRAC_BITS);
    localparam logic signed [CHARGE_W-1:0] CHARGE_RST = -CHARGE_W'(4 << FRAC_BITS);
    localparam logic [PEN_W-1:0]           OPEN_RST   = PEN_W'(40);
    localparam logic [PEN_W-1:0]           EXTEND_RST = PEN_W'(2);

    // input kinds
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ROW  = 1'b1;

    // nucleotide letters
    localparam logic [BASE_W-1:0] CH_A = 8'h41;
    localparam logic [BASE_W-1:0] CH_C = 8'h43;
    localparam logic [BASE_W-1:0] CH_G = 8'h47;
    localparam logic [BASE_W-1:0] CH_T = 8'h54;

    typedef struct packed {
        logic [AWARD_W-1:0]         award;
        logic signed [CHARGE_W-1:0] charge;
        logic [PEN_W-1:0]           open_pen;
        logic [PEN_W-1:0]           ext_pen;
    } t_cfg;

    typedef struct packed {
        logic load_we;    // write query base at load address
        logic job_start;  // clear best score
        logic base_we;    // latch reference base
        logic issue;      // start a column down the pipeline
        logic first_col;
        logic last_col;
        logic first_row;  // row above reads as zero
    } t_cmd;

    typedef struct packed {
        logic adv;        // pipeline may move this cycle
        logic busy;       // columns still in flight
    } t_stat;

endpackage

### sv/lafd_ctrl.sv
`timescale 1ns / 1ps

module lafd_ctrl #(
    parameter int MAX_QUERY = 64,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_op,
    input  logic            i_last,
    input  lafd_pkg::t_stat i_stat,
    output lafd_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]   o_addr
);
    import lafd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_ROW, ST_DRAIN} t_state;

    t_state        r_state, n_state;
    logic          r_loading, n_loading;
    logic [CW-1:0] r_count, n_count;
    logic          r_first_row, n_first_row;
    logic          r_row_last, n_row_last;
    logic [AW-1:0] r_col, n_col;

    logic          acc;
    logic [CW-1:0] eff_count;
    logic          room;
    logic          last_col;

    assign acc       = i_valid && (r_state == ST_IDLE);
    assign eff_count = (i_op == OP_LOAD && !r_loading) ? '0 : r_count;
    assign room      = eff_count < CW'(MAX_QUERY);
    assign last_col  = (CW'(r_col) + CW'(1)) == r_count;

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd.load_we   = acc && (i_op == OP_LOAD) && room;
        o_cmd.job_start = acc && (((i_op == OP_ROW) && r_loading) ||
                                  ((i_op == OP_LOAD) && i_last));
        o_cmd.base_we   = acc && (i_op == OP_ROW);
        o_cmd.issue     = (r_state == ST_ROW) && i_stat.adv;
        o_cmd.first_col = (r_col == '0);
        o_cmd.last_col  = last_col;
        o_cmd.first_row = r_first_row;
        o_addr          = (r_state == ST_IDLE) ? AW'(eff_count) : r_col;
    end

    always_comb begin
        n_state     = r_state;
        n_loading   = r_loading;
        n_count     = r_count;
        n_first_row = r_first_row;
        n_row_last  = r_row_last;
        n_col       = r_col;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (i_op == OP_LOAD) begin
                        n_count   = room ? eff_count + CW'(1) : eff_count;
                        n_loading = !i_last;
                        if (i_last) begin
                            n_first_row = 1'b1;
                        end
                    end else begin
                        n_loading = 1'b0;
                        if (r_loading) begin
                            n_first_row = 1'b1;
                        end
                        if (r_count == '0) begin
                            // empty query: no cells, may still close the job
                            if (i_last) begin
                                n_loading = 1'b1;
                                n_count   = '0;
                            end
                        end else begin
                            n_state    = ST_ROW;
                            n_col      = '0;
                            n_row_last = i_last;
                        end
                    end
                end
            end
            ST_ROW: begin
                if (i_stat.adv) begin
                    if (last_col) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_col = r_col + AW'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state     = ST_IDLE;
                    n_first_row = 1'b0;
                    if (r_row_last) begin
                        n_loading = 1'b1;
                        n_count   = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_loading   <= 1'b1;
            r_count     <= '0;
            r_first_row <= 1'b1;
            r_row_last  <= 1'b0;
            r_col       <= '0;
        end else begin
            r_state     <= n_state;
            r_loading   <= n_loading;
            r_count     <= n_count;
            r_first_row <= n_first_row;
            r_row_last  <= n_row_last;
            r_col       <= n_col;
        end
    end

endmodule

### sv/lafd_dp.sv
`timescale 1ns / 1ps

module lafd_dp #(
    parameter int MAX_QUERY = 64,
    parameter int AW = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lafd_pkg::t_cfg                i_cfg,
    input  lafd_pkg::t_cmd                i_cmd,
    input  logic [AW-1:0]                 i_addr,
    input  logic [lafd_pkg::BASE_W-1:0]   i_base,
    output lafd_pkg::t_stat               o_stat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lafd_pkg::CODE_W-1:0]   o_code,
    output logic [lafd_pkg::COL_W-1:0]    o_col,
    output logic [lafd_pkg::SCORE_W-1:0]  o_score,
    output logic [lafd_pkg::SCORE_W-1:0]  o_best,
    output logic                          o_last
);
    import lafd_pkg::*;

    typedef logic signed [GAP_W-1:0] t_val;

    // memories
    logic [BASE_W-1:0]  r_qmem [MAX_QUERY];
    logic [SCORE_W-1:0] r_smem [MAX_QUERY];
    t_val               r_gmem [MAX_QUERY];

    logic              adv;
    logic [BASE_W-1:0] r_base;

    // stage 1: registered memory reads
    logic               r_v1;
    logic [AW-1:0]      r1_col;
    logic               r1_first_col, r1_last_col, r1_first_row;
    logic [BASE_W-1:0]  r1_q;
    logic [SCORE_W-1:0] r1_s;
    t_val               r1_g;
    t_val               r_prev_up;

    // stage 2: diag and vertical gap ready
    logic          r_v2;
    logic [AW-1:0] r2_col;
    logic          r2_first_col, r2_last_col;
    t_val          r2_diag, r2_f;
    t_val          r_e, r_hl;
    logic [SCORE_W-1:0] r_best;

    // output register
    logic               r_ov;
    logic [CODE_W-1:0]  r_ocode;
    logic [COL_W-1:0]   r_ocol;
    logic [SCORE_W-1:0] r_oscore, r_obest;
    logic               r_olast;

    t_val ext, opn;
    t_val sub, up_h, gap, f, diag;
    t_val e_prev, hl_prev, e, max_de, max_fz, h_full;
    logic [SCORE_W-1:0] h, best_new;
    logic [CODE_W-1:0]  code;
    logic acgt;

    assign adv    = !r_ov || i_ready;
    assign o_stat = '{adv: adv, busy: r_v1 || r_v2};

    assign ext = t_val'({1'b0, i_cfg.ext_pen});
    assign opn = t_val'({1'b0, i_cfg.open_pen});

    // stage 1 math
    always_comb begin
        acgt = (r1_q == CH_A) || (r1_q == CH_C) || (r1_q == CH_G) || (r1_q == CH_T);
        if (acgt && (r1_q == r_base)) begin
            sub = t_val'({1'b0, i_cfg.award});
        end else begin
            sub = t_val'(i_cfg.charge);
        end
        up_h = r1_first_row ? '0 : t_val'({1'b0, r1_s});
        gap  = r1_first_row ? '0 : r1_g;
        f    = ((gap - ext) > (up_h - opn)) ? gap - ext : up_h - opn;
        diag = (r1_first_col ? t_val'(0) : r_prev_up) + sub;
    end

    // stage 2 math: horizontal gap, cell score, direction
    always_comb begin
        e_prev  = r2_first_col ? '0 : r_e;
        hl_prev = r2_first_col ? '0 : r_hl;
        e       = ((e_prev - ext) > (hl_prev - opn)) ? e_prev - ext : hl_prev - opn;
        max_de  = (r2_diag > e) ? r2_diag : e;
        max_fz  = (r2_f > 0) ? r2_f : '0;
        code    = {r2_diag >= e, r2_f >= 0, max_de >= max_fz};
        h_full  = (max_de > max_fz) ? max_de : max_fz;
        h       = (h_full > t_val'({1'b0, SCORE_CAP})) ? SCORE_CAP : h_full[SCORE_W-1:0];
        best_new = (h > r_best) ? h : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_qmem[i_addr] <= i_base;
        end
        if (adv && r_v2) begin
            r_smem[r2_col] <= h;
            r_gmem[r2_col] <= r2_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.base_we) begin
            r_base <= i_base;
        end
        if (adv) begin
            r1_q         <= r_qmem[i_addr];
            r1_s         <= r_smem[i_addr];
            r1_g         <= r_gmem[i_addr];
            r1_col       <= i_addr;
            r1_first_col <= i_cmd.first_col;
            r1_last_col  <= i_cmd.last_col;
            r1_first_row <= i_cmd.first_row;
            if (r_v1) begin
                r_prev_up <= up_h;
            end
            r2_col       <= r1_col;
            r2_first_col <= r1_first_col;
            r2_last_col  <= r1_last_col;
            r2_diag      <= diag;
            r2_f         <= f;
            if (r_v2) begin
                r_e      <= e;
                r_hl     <= t_val'({1'b0, h});
                r_ocode  <= code;
                r_ocol   <= COL_W'(r2_col);
                r_oscore <= h;
                r_obest  <= best_new;
                r_olast  <= r2_last_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_ov   <= 1'b0;
            r_best <= '0;
        end else begin
            if (adv) begin
                r_v1 <= i_cmd.issue;
                r_v2 <= r_v1;
                r_ov <= r_v2;
                if (r_v2) begin
                    r_best <= best_new;
                end
            end
            if (i_cmd.job_start) begin
                r_best <= '0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_code  = r_ocode;
    assign o_col   = r_ocol;
    assign o_score = r_oscore;
    assign o_best  = r_obest;
    assign o_last  = r_olast;

endmodule

### sv/local_alignment_fill_with_directions.sv
`timescale 1ns / 1ps
// Flow: a reference base passes the sequencer state, stage 1, stage 2 and the output register
//   before its first cell comes out, then one cell per cycle while the output is taken.
// A row is walked by the single column pipeline, one address per cycle while the output is
//   taken; the next base is not accepted until the row has drained.
// Reset (synchronous, active low) clears control, counters and best score; config returns to
//   its defaults. Query and row memories are not cleared; the first row of a job reads zeros.

module local_alignment_fill_with_directions #(
    parameter int MAX_QUERY = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // reference/query stream in
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [7:0]                         i_s_axis_tdata,  // [7:0] base
    input  logic                               i_s_axis_tuser,  // [0] op: 0 load, 1 row
    input  logic                               i_s_axis_tlast,
    // cell stream out
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [2:0] direction_code, [8:3] column, [24:9] cell_score, [40:25] best_so_far, rest zero
    output logic [lafd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast,  // last_of_row
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lafd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lafd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lafd_pkg::*;

    localparam int AW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int CW = $clog2(MAX_QUERY + 1);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;
    logic [AW-1:0] addr;

    logic [CODE_W-1:0]  code;
    logic [COL_W-1:0]   col;
    logic [SCORE_W-1:0] score, best;

    // config writes are always taken; the block is idle by contract
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.award    <= AWARD_RST;
            r_cfg.charge   <= CHARGE_RST;
            r_cfg.open_pen <= OPEN_RST;
            r_cfg.ext_pen  <= EXTEND_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AWARD:  r_cfg.award    <= i_cfg_data[AWARD_W-1:0];
                CFG_CHARGE: r_cfg.charge   <= i_cfg_data[CHARGE_W-1:0];
                CFG_OPEN:   r_cfg.open_pen <= i_cfg_data[PEN_W-1:0];
                CFG_EXTEND: r_cfg.ext_pen  <= i_cfg_data[PEN_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: query loading, job start/end, column walk
    lafd_ctrl #(
        .MAX_QUERY (MAX_QUERY),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_op    (i_s_axis_tuser),
        .i_last  (i_s_axis_tlast),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_addr  (addr)
    );

    // row memories, cell pipeline and output register
    lafd_dp #(
        .MAX_QUERY (MAX_QUERY),
        .AW        (AW)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (cmd),
        .i_addr  (addr),
        .i_base  (i_s_axis_tdata),
        .o_stat  (stat),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_code  (code),
        .o_col   (col),
        .o_score (score),
        .o_best  (best),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {7'b0, best, score, col, code};

endmodule

### sv/lafd_checker.sv
`timescale 1ns / 1ps

module lafd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // a stalled cell holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output cell changed while stalled");

    // best of job never below the cell it comes with
    a_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[40:25] >= o_m_axis_tdata[24:9])
        else $error("best score below cell score");

    // no new item while a row is still coming out
    a_row_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input taken in the middle of a row");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind local_alignment_fill_with_directions lafd_checker u_lafd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

### tb/tb_local_alignment_fill_with_directions.sv
`timescale 1ns / 1ps

module tb_local_alignment_fill_with_directions;
    import lafd_pkg::*;

    localparam int QMAX          = 64;
    localparam int SETTLE_CYCLES = 80;      // longest row is 64 cells, plus the pipe to drain
    localparam int HOLD_CYCLES   = 400;     // long sink stall, backs the row pipe up
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 80;
    localparam int PRINT_CAP     = 60;

    // one expected cell of the score matrix
    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [COL_W-1:0]   col;
        logic [SCORE_W-1:0] score;
        logic [SCORE_W-1:0] best;
        logic               eor;
    } t_cell;

    // one base on the input stream
    typedef struct packed {
        logic              op;
        logic [BASE_W-1:0] base;
        logic              last;
    } t_feed;

    // directed table row: a base, and the cell it gives when that is obvious
    typedef struct packed {
        t_feed  item;
        logic   typed;
        t_cell  want;
    } t_dir;

    localparam t_cell NO_CELL = '0;
    localparam int    DIR_N   = 21;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [BASE_W-1:0] i_s_axis_tdata  = '0;
    logic              i_s_axis_tuser  = 1'b0;
    logic              i_s_axis_tlast  = 1'b0;

    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // matrix predictor state
    logic [BASE_W-1:0] query_mem [QMAX];
    int                query_len;
    int                above_score [QMAX];
    int                above_gap [QMAX];
    int                best_cell;
    bit                loading;
    int                award_q, charge_q, open_q, ext_q;

    t_cell cell_queue [$];
    t_feed feed_q [$];
    int    fed_count;
    t_dir  dir_tab [DIR_N];

    int errors = 0;
    int snd_idle = 0;                 // percent of cycles the source holds back
    int rcv_idle = 0;                 // percent of cycles the sink holds back
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    local_alignment_fill_with_directions uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] base
        .i_s_axis_tuser  (i_s_axis_tuser),   // [0] op
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [2:0] code, [8:3] col, [24:9] cell, [40:25] best
        .o_m_axis_tlast  (o_m_axis_tlast),   // last_of_row
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb_local_alignment_fill_with_directions: FAIL");
        $finish;
    end

    task automatic note_mismatch(input string what, input longint got, input longint want);
        if (errors < PRINT_CAP)
            $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    // new job: row above reads as zero, best score restarts
    task automatic clear_job();
        for (int j = 0; j < QMAX; j++) begin
            above_score[j] = 0;
            above_gap[j]   = 0;
        end
        best_cell = 0;
    endtask

    // Advance the matrix by one accepted base; a reference base queues one cell per
    // query column unless keep is low (directed rows with a typed expectation).
    task automatic advance_matrix(input t_feed it, input bit keep);
        int    h_left, e, above_left, sub, up_h, diag, f, max_de, max_fz, h;
        t_cell c;
        h_left = 0;
        e = 0;
        above_left = 0;
        if (it.op == OP_LOAD) begin
            if (!loading) begin
                query_len = 0;
                loading   = 1'b1;
            end
            if (query_len < QMAX) begin
                query_mem[query_len] = it.base;
                query_len++;
            end
            if (it.last) begin
                clear_job();
                loading = 1'b0;
            end
        end else begin
            if (loading) begin
                clear_job();
                loading = 1'b0;
            end
            for (int j = 0; j < query_len; j++) begin
                sub = (query_mem[j] == it.base && (it.base == CH_A || it.base == CH_C ||
                       it.base == CH_G || it.base == CH_T)) ? award_q : charge_q;
                up_h   = above_score[j];
                e      = (e - ext_q > h_left - open_q) ? e - ext_q : h_left - open_q;
                diag   = above_left + sub;
                f      = (above_gap[j] - ext_q > up_h - open_q) ? above_gap[j] - ext_q
                                                                : up_h - open_q;
                max_de = (diag > e) ? diag : e;
                max_fz = (f > 0) ? f : 0;
                h      = (max_de > max_fz) ? max_de : max_fz;
                if (h > int'(SCORE_CAP)) h = int'(SCORE_CAP);
                c.code = {diag >= e, f >= 0, max_de >= max_fz};
                above_left     = up_h;
                above_score[j] = h;
                above_gap[j]   = f;
                h_left         = h;
                if (h > best_cell) best_cell = h;
                c.col   = j[COL_W-1:0];
                c.score = h[SCORE_W-1:0];
                c.best  = best_cell[SCORE_W-1:0];
                c.eor   = (j + 1 == query_len);
                if (keep) cell_queue.push_back(c);
            end
            if (it.last) begin
                loading   = 1'b1;
                query_len = 0;
            end
        end
    endtask

    // offer one base, with random gaps ahead of it; valid stays up into the next base
    task automatic send_base(input t_feed it, input bit keep);
        while (snd_idle != 0 && $urandom_range(0, 99) < snd_idle) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= it.base;
        i_s_axis_tuser  <= it.op;
        i_s_axis_tlast  <= it.last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        advance_matrix(it, keep);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_AWARD:  award_q  = int'(val[AWARD_W-1:0]);
            CFG_CHARGE: charge_q = int'($signed(val));
            CFG_OPEN:   open_q   = int'(val[PEN_W-1:0]);
            CFG_EXTEND: ext_q    = int'(val[PEN_W-1:0]);
            default: ;
        endcase
    endtask

    // all cells in, then let loads and the tail of the pipe settle
    task automatic settle();
        while (cell_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [BASE_W-1:0] pick_base();
        if ($urandom_range(0, 99) < 15) return BASE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       return CH_A;
            1:       return CH_C;
            2:       return CH_G;
            default: return CH_T;
        endcase
    endfunction

    // queue a load of len bases and rows reference bases; the close flags drop tlast
    // on the final load or row to make broken sequences
    function automatic void add_job(input int len, input int rows, input bit close_load,
                                    input bit close_job);
        t_feed it;
        for (int k = 0; k < len; k++) begin
            it.op   = OP_LOAD;
            it.base = pick_base();
            it.last = close_load && (k == len - 1);
            feed_q.push_back(it);
            if (k < QMAX) fed_count++;    // bases past the end are dropped by the block
        end
        for (int k = 0; k < rows; k++) begin
            it.op   = OP_ROW;
            it.base = pick_base();
            it.last = close_job && (k == rows - 1);
            feed_q.push_back(it);
            fed_count++;
        end
    endfunction

    function automatic void build_phase(input bit with_long);
        int    kind;
        t_feed it;
        fed_count = 0;
        if (with_long) add_job($urandom_range(QMAX, QMAX + 4), $urandom_range(1, 3), 1'b1, 1'b1);
        while (fed_count < PHASE_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                add_job($urandom_range(1, 10), $urandom_range(1, 6), 1'b1, 1'b1);
            end else if (kind < 85) begin
                // rows straight after an open load start the job themselves
                add_job($urandom_range(1, 10), $urandom_range(1, 4), 1'b0, 1'b1);
            end else if (kind < 93) begin
                // job left open, the next load throws it away
                add_job($urandom_range(1, 10), $urandom_range(1, 4), 1'b1, 1'b0);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    it.op   = logic'($urandom_range(0, 1));
                    it.base = BASE_W'($urandom_range(0, 255));
                    it.last = ($urandom_range(0, 3) == 0);
                    feed_q.push_back(it);
                    fed_count++;
                end
            end
        end
    endfunction

    // sink side: random back-pressure, plus one long stall on request
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    // every cell transfer against the oldest expected cell
    always @(posedge i_clk) begin : cell_check
        t_cell want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (cell_queue.size() == 0) begin
                note_mismatch("cell with none expected, column", o_m_axis_tdata[8:3], -1);
            end else begin
                want = cell_queue.pop_front();
                if (o_m_axis_tdata[2:0] !== want.code)
                    note_mismatch("direction_code", o_m_axis_tdata[2:0], want.code);
                if (o_m_axis_tdata[8:3] !== want.col)
                    note_mismatch("column", o_m_axis_tdata[8:3], want.col);
                if (o_m_axis_tdata[24:9] !== want.score)
                    note_mismatch("cell_score", o_m_axis_tdata[24:9], want.score);
                if (o_m_axis_tdata[40:25] !== want.best)
                    note_mismatch("best_so_far", o_m_axis_tdata[40:25], want.best);
                if (o_m_axis_tlast !== want.eor)
                    note_mismatch("last_of_row", o_m_axis_tlast, want.eor);
                if (o_m_axis_tdata[OUT_DATA_W-1:41] !== '0)
                    note_mismatch("tdata pad bits", o_m_axis_tdata[OUT_DATA_W-1:41], 0);
            end
        end
    end

    initial begin
        // directed rows; defaults are award 20, charge -16, open 40, extend 2
        dir_tab[0]  = {OP_ROW,  CH_A,  1'b0, 1'b0, NO_CELL};  // empty query, starts a job
        dir_tab[1]  = {OP_ROW,  CH_A,  1'b1, 1'b0, NO_CELL};  // empty query, ends it
        dir_tab[2]  = {OP_LOAD, CH_A,  1'b1, 1'b0, NO_CELL};
        dir_tab[3]  = {OP_ROW,  CH_A,  1'b0, 1'b1, 3'b101, 6'd0, 16'd20, 16'd20, 1'b1};
        dir_tab[4]  = {OP_ROW,  CH_C,  1'b1, 1'b1, 3'b000, 6'd0, 16'd0,  16'd20, 1'b1};
        dir_tab[5]  = {OP_LOAD, 8'h61, 1'b1, 1'b0, NO_CELL};  // lower-case a
        dir_tab[6]  = {OP_ROW,  8'h61, 1'b1, 1'b1, 3'b000, 6'd0, 16'd0,  16'd0,  1'b1};
        dir_tab[7]  = {OP_LOAD, 8'h00, 1'b0, 1'b0, NO_CELL};
        dir_tab[8]  = {OP_LOAD, 8'hFF, 1'b0, 1'b0, NO_CELL};
        dir_tab[9]  = {OP_LOAD, CH_G,  1'b0, 1'b0, NO_CELL};
        dir_tab[10] = {OP_LOAD, CH_T,  1'b1, 1'b0, NO_CELL};
        dir_tab[11] = {OP_ROW,  CH_G,  1'b0, 1'b0, NO_CELL};
        dir_tab[12] = {OP_ROW,  8'hFF, 1'b0, 1'b0, NO_CELL};  // equal but not a nucleotide
        dir_tab[13] = {OP_ROW,  CH_T,  1'b1, 1'b0, NO_CELL};
        dir_tab[14] = {OP_LOAD, CH_A,  1'b0, 1'b0, NO_CELL};
        dir_tab[15] = {OP_LOAD, CH_C,  1'b1, 1'b0, NO_CELL};
        dir_tab[16] = {OP_LOAD, CH_T,  1'b0, 1'b0, NO_CELL};  // load after close restarts
        dir_tab[17] = {OP_ROW,  CH_T,  1'b0, 1'b0, NO_CELL};  // row on an open load
        dir_tab[18] = {OP_ROW,  CH_C,  1'b0, 1'b0, NO_CELL};
        dir_tab[19] = {OP_LOAD, CH_G,  1'b1, 1'b0, NO_CELL};  // drops the open job
        dir_tab[20] = {OP_ROW,  CH_G,  1'b1, 1'b0, NO_CELL};

        // predictor matches the block after reset
        award_q   = int'(AWARD_RST);
        charge_q  = int'(CHARGE_RST);
        open_q    = int'(OPEN_RST);
        ext_q     = int'(EXTEND_RST);
        query_len = 0;
        loading   = 1'b1;
        clear_job();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                case (p)
                    1: begin
                        cfg_write(CFG_AWARD,  11'd1023);
                        cfg_write(CFG_CHARGE, 11'h400);     // -1024
                        cfg_write(CFG_OPEN,   11'd0);
                        cfg_write(CFG_EXTEND, 11'd0);
                    end
                    2: begin
                        cfg_write(CFG_AWARD,  11'd0);
                        cfg_write(CFG_CHARGE, 11'd0);
                        cfg_write(CFG_OPEN,   11'd1023);
                        cfg_write(CFG_EXTEND, 11'd1023);
                    end
                    4: begin
                        cfg_write(CFG_AWARD,  11'd1023);
                        cfg_write(CFG_CHARGE, 11'd0);
                        cfg_write(CFG_OPEN,   11'd1023);
                        cfg_write(CFG_EXTEND, 11'd0);
                    end
                    default: begin
                        // top bit is outside the 10-bit registers and must be ignored
                        cfg_write(CFG_AWARD,  CFG_DATA_W'($urandom_range(0, 2047)));
                        cfg_write(CFG_CHARGE, CFG_DATA_W'(-$urandom_range(0, 1024)));
                        cfg_write(CFG_OPEN,   CFG_DATA_W'($urandom_range(0, 2047)));
                        cfg_write(CFG_EXTEND, CFG_DATA_W'($urandom_range(0, 63)));
                    end
                endcase
                i_cfg_valid <= 1'b0;
            end

            // sink-heavy idling, then source-heavy, then none
            snd_idle = (p < 2) ? 27 : (p < 4) ? 47 : 0;
            rcv_idle = (p < 2) ? 47 : (p < 4) ? 27 : 0;

            if (p == 0) begin
                for (int i = 0; i < DIR_N; i++) begin
                    send_base(dir_tab[i].item, !dir_tab[i].typed);
                    if (dir_tab[i].typed) cell_queue.push_back(dir_tab[i].want);
                end
            end

            build_phase(p == 1 || p == 4);
            if (p == 3) hold_go = 1'b1;
            while (feed_q.size() != 0) send_base(feed_q.pop_front(), 1'b1);
            i_s_axis_tvalid <= 1'b0;
        end

        settle();
        if (errors == 0) begin
            $display("tb_local_alignment_fill_with_directions: PASS");
        end else begin
            $display("tb_local_alignment_fill_with_directions: FAIL");
        end
        $finish;
    end

endmodule
